FILE: hw/rtl/uice_pkg.sv
// shared types, constants and functions for the universal integer code encoder
// no dependencies
package uice_pkg;

   localparam int ValueBitsMax = 32;
   localparam int WordBits = 64;
   localparam int LenBits = 6;
   localparam int FibTerms = 47;
   localparam int FibIdxBits = 6;

   typedef enum logic [1:0] {
      CODE_GAMMA = 2'd0,
      CODE_DELTA = 2'd1,
      CODE_OMEGA = 2'd2,
      CODE_FIB   = 2'd3
   } code_kind_type;

   typedef logic [WordBits-1:0] word_type;
   typedef logic [LenBits-1:0] len_type;

   typedef struct packed {
      word_type code_word;
      len_type  code_length;
      logic     invalid_value;
   } code_result_type;

   function automatic logic [47:0] fib_term(input logic [FibIdxBits-1:0] idx);
      logic [47:0] a;
      logic [47:0] b;
      logic [47:0] t;
      a = 48'd1;
      b = 48'd2;
      for (int i = 0; i < 64; i++) begin
         if (i < int'(idx)) begin
            t = a + b;
            a = b;
            b = t;
         end
      end
      return a;
   endfunction

   function automatic logic [5:0] bit_len32(input logic [31:0] v);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) n = 6'(i + 1);
      end
      return n;
   endfunction

endpackage

FILE: hw/rtl/uice_stream_if.sv
// valid/ready channel interface carrying a typed payload
// no dependencies
interface uice_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/uice_fib_stage.sv
// one greedy zeckendorf step group: tests and subtracts a slice of fibonacci terms
// depends on uice_pkg
module uice_fib_stage
   import uice_pkg::*;
#(
   parameter int HI = 46,
   parameter int LO = 0
) (
   input  logic [31:0] rest_in,
   input  logic [63:0] used_in,
   output logic [31:0] rest_out,
   output logic [63:0] used_out
);
   always_comb begin
      logic [47:0] r;
      logic [47:0] f;
      r = {16'd0, rest_in};
      used_out = used_in;
      for (int i = HI; i >= LO; i--) begin
         f = fib_term(FibIdxBits'(i));
         if (f <= r) begin
            r = r - f;
            used_out[i] = 1'b1;
         end
      end
      rest_out = r[31:0];
   end
endmodule

FILE: hw/rtl/universal_integer_code_encoder.sv
// channel  dir  payload
// req      in   value[31:0]
// rsp      out  code_word[63:0], code_length[5:0], invalid_value
// csr      in   code_kind write
// seven register stages: six zeckendorf slices of up to eight terms, the first also masking,
// measuring bit length and building omega groups; the last assembles the word
// one transaction per cycle while the pipeline advances; a stalled rsp holds it
// the pipeline advances when the last stage is empty or taken; valid bits follow data
// synchronous active-high reset clears valid bits and code_kind
// depends on uice_pkg, uice_stream_if, uice_fib_stage
module universal_integer_code_encoder
   import uice_pkg::*;
#(
   parameter int VALUE_BITS = ValueBitsMax
) (
   input  logic       clock,
   input  logic       reset,
   uice_stream_if.sink   req,
   uice_stream_if.source rsp,
   input  logic       csr_we,
   input  logic [1:0] csr_wdata
);
   localparam int FibSlice = 8;
   localparam int FibStages = (FibTerms + FibSlice - 1) / FibSlice;
   localparam int NS = FibStages + 1;

   typedef struct packed {
      logic [31:0]   value;
      logic [5:0]    len;
      code_kind_type kind;
      logic [31:0]   rest;
      logic [63:0]   used;
      logic [63:0]   omega_word;
      logic [5:0]    omega_len;
   } stage_type;

   code_kind_type kind_ff;
   always_ff @(posedge clock) begin
      if (reset) kind_ff <= CODE_GAMMA;
      else if (csr_we) kind_ff <= code_kind_type'(csr_wdata);
   end

   logic [NS-1:0] vld_ff;
   logic adv;
   assign adv = !vld_ff[NS-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NS-2:0], req.valid};
   end

   // entry: mask, bit length, omega groups
   logic [31:0] v_in;
   stage_type   st_first;
   stage_type   st_ff [FibStages];
   assign v_in = req.payload & 32'((64'd1 << VALUE_BITS) - 64'd1);

   always_comb begin
      logic [31:0] n;
      logic [5:0]  b;
      st_first.value = v_in;
      st_first.len = bit_len32(v_in);
      st_first.kind = kind_ff;
      st_first.rest = v_in;
      st_first.used = '0;
      st_first.omega_word = '0;
      st_first.omega_len = 6'd1;
      n = v_in;
      b = bit_len32(v_in);
      for (int i = 0; i < 5; i++) begin
         if (n > 32'd1) begin
            st_first.omega_word = st_first.omega_word | (64'(n) << st_first.omega_len);
            st_first.omega_len = st_first.omega_len + b;
            n = 32'(b - 6'd1);
            b = bit_len32(n);
         end
      end
   end

   // zeckendorf slices, largest terms first
   for (genvar s = 0; s < FibStages; s++) begin : g_stage
      localparam int Hi = FibTerms - 1 - FibSlice * s;
      localparam int Lo = (Hi >= FibSlice) ? Hi - FibSlice + 1 : 0;
      stage_type   st_src;
      stage_type   st_in;
      logic [31:0] rest_next;
      logic [63:0] used_next;

      if (s == 0) begin : g_head
         assign st_src = st_first;
      end else begin : g_body
         assign st_src = st_ff[s-1];
      end

      uice_fib_stage #(.HI(Hi), .LO(Lo)) u_fib (
         .rest_in(st_src.rest), .used_in(st_src.used),
         .rest_out(rest_next), .used_out(used_next));

      always_comb begin
         st_in = st_src;
         st_in.rest = rest_next;
         st_in.used = used_next;
      end

      always_ff @(posedge clock) begin
         if (adv) st_ff[s] <= st_in;
      end
   end

   // last stage: assemble word per code
   stage_type   st_last;
   logic [63:0] w_in, w_ff;
   logic [5:0]  len_in, len_ff;
   logic        inv_in, inv_ff;
   logic [5:0]  top;
   logic [5:0]  nl;
   logic [63:0] lowm;

   assign st_last = st_ff[FibStages-1];

   always_comb begin
      top = '0;
      for (int i = 0; i < FibTerms; i++) begin
         if (fib_term(FibIdxBits'(i)) <= {16'd0, st_last.value}) top = 6'(i);
      end
      nl = bit_len32({26'd0, st_last.len});
      lowm = (64'd1 << (st_last.len - 6'd1)) - 64'd1;
      w_in = '0;
      len_in = '0;
      inv_in = (st_last.value == 32'd0);
      unique case (st_last.kind)
         CODE_GAMMA: begin
            w_in = 64'(st_last.value);
            len_in = 6'((st_last.len << 1) - 6'd1);
         end
         CODE_DELTA: begin
            w_in = (64'(st_last.len) << (st_last.len - 6'd1)) | (64'(st_last.value) & lowm);
            len_in = (nl - 6'd1) + nl + (st_last.len - 6'd1);
         end
         CODE_OMEGA: begin
            w_in = st_last.omega_word;
            len_in = st_last.omega_len;
         end
         CODE_FIB: begin
            for (int i = 0; i < FibTerms; i++) begin
               if (6'(i) <= top) w_in[top - 6'(i) + 6'd1] = st_last.used[i];
            end
            w_in[0] = 1'b1;
            len_in = top + 6'd2;
         end
         default: ;
      endcase
      if (inv_in) begin
         w_in = '0;
         len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff <= w_in; len_ff <= len_in; inv_ff <= inv_in;
      end
   end

   assign rsp.valid = vld_ff[NS-1];
   assign rsp.payload.code_word = w_ff;
   assign rsp.payload.code_length = len_ff;
   assign rsp.payload.invalid_value = inv_ff;
endmodule
